// ===== hdl/hash_map_linear_probe_top_defines.svh =====
// assertion macros for the hash map block
// used by hash_map_linear_probe_top; expects clk_i and rst_ni in scope
`ifndef HASH_MAP_LINEAR_PROBE_TOP_DEFINES_SVH
`define HASH_MAP_LINEAR_PROBE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HMLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HMLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define HMLP_ASSERT(lbl, prop, msg)
`define HMLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/hmlp_pkg.sv =====
// shared types and constants of the hash map block
// no dependencies
package hmlp_pkg;

  localparam logic [63:0] HASH_SEED       = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [3:0]  SIZE_LOG2_RESET = 4'd10;
  localparam logic [3:0]  SIZE_LOG2_MIN   = 4'd2;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_REPLACED  = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4,
    STS_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_RESP
  } fsm_e;

endpackage

// ===== hdl/hmlp_ram.sv =====
// bucket memory: one write port, one read port, registered read data
// no dependencies
module hmlp_ram #(
  parameter int AW = 10,
  parameter int EW = 65
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [2**AW];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hmlp_ctrl.sv =====
// probe sequencer, clearing pass and result register of the hash map
// depends on hmlp_pkg; drives the bucket memory hmlp_ram
module hmlp_ctrl #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 10,
  parameter int CW          = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [3:0]             size_log2_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [VALUE_WIDTH-1:0] found_value_o,
  output logic [CW-1:0]          entry_count_o,
  output logic                   ram_we_o,
  output logic [AW-1:0]          ram_waddr_o,
  output logic [KEY_WIDTH+VALUE_WIDTH:0] ram_wdata_o,
  output logic [AW-1:0]          ram_raddr_o,
  input  logic [KEY_WIDTH+VALUE_WIDTH:0] ram_rdata_i
);

  localparam int EW = KEY_WIDTH + VALUE_WIDTH + 1;

  hmlp_pkg::fsm_e state_q, state_d;
  logic                   is_put_q, is_put_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [AW:0]            probe_q, probe_d;
  logic [AW-1:0]          clr_addr_q, clr_addr_d;
  logic                   clr_pend_q, clr_pend_d;
  logic [CW-1:0]          count_q, count_d;
  logic [2:0]             resp_q, resp_d;
  logic                   out_valid_q, out_valid_d;
  logic [2:0]             out_status_q, out_status_d;
  logic [VALUE_WIDTH-1:0] out_found_q, out_found_d;
  logic [CW-1:0]          out_count_q, out_count_d;

  logic [4:0]             s_eff;
  logic [AW:0]            cap;
  logic [AW-1:0]          mask;
  logic [AW-1:0]          home;
  logic [AW-1:0]          next_idx;
  logic                   r_occ;
  logic [KEY_WIDTH-1:0]   r_key;
  logic [VALUE_WIDTH-1:0] r_val;
  logic                   hit, hole, last, done, slot_free;
  logic [2:0]             probe_status;
  logic [AW-1:0]          hashed;

  // bucket count saturates at the memory depth, floor of four buckets
  always_comb begin
    if (size_log2_i < hmlp_pkg::SIZE_LOG2_MIN) begin
      s_eff = {1'b0, hmlp_pkg::SIZE_LOG2_MIN};
    end else if ({1'b0, size_log2_i} > 5'(AW)) begin
      s_eff = 5'(AW);
    end else begin
      s_eff = {1'b0, size_log2_i};
    end
  end

  assign cap      = (AW+1)'(1) << s_eff;
  assign mask     = AW'(cap - (AW+1)'(1));
  assign hashed   = AW'(64'(key_i) ^ hmlp_pkg::HASH_SEED);
  assign home     = hashed & mask;
  assign next_idx = (idx_q + AW'(1)) & mask;

  assign r_occ = ram_rdata_i[EW-1];
  assign r_key = ram_rdata_i[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
  assign r_val = ram_rdata_i[VALUE_WIDTH-1:0];

  assign hit       = r_occ && (r_key == key_q);
  assign hole      = !r_occ;
  assign last      = (probe_q + (AW+1)'(1)) == cap;
  assign done      = hit || hole || last;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (is_put_q) begin
      probe_status = hole ? hmlp_pkg::STS_INSERTED :
                     hit  ? hmlp_pkg::STS_REPLACED : hmlp_pkg::STS_FULL;
    end else begin
      probe_status = hit ? hmlp_pkg::STS_FOUND : hmlp_pkg::STS_NOT_FOUND;
    end
  end

  always_comb begin
    state_d      = state_q;
    is_put_d     = is_put_q;
    key_d        = key_q;
    val_d        = val_q;
    idx_d        = idx_q;
    probe_d      = probe_q;
    clr_addr_d   = clr_addr_q;
    clr_pend_d   = clr_pend_q;
    count_d      = count_q;
    resp_d       = resp_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = idx_q;
    ram_wdata_o  = {1'b1, key_q, val_q};
    ram_raddr_o  = idx_q;
    in_stall_o   = 1'b1;

    case (state_q)
      hmlp_pkg::S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_addr_q;
        ram_wdata_o = '0;
        if (clr_addr_q == '1) begin
          if (clr_pend_q) begin
            resp_d     = hmlp_pkg::STS_CLEARED;
            clr_pend_d = 1'b0;
            state_d    = hmlp_pkg::S_RESP;
          end else begin
            state_d = hmlp_pkg::S_IDLE;
          end
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end

      hmlp_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        ram_raddr_o = home;
        if (in_valid_i) begin
          is_put_d = (action_i == hmlp_pkg::ACT_PUT);
          key_d    = key_i;
          val_d    = value_i;
          idx_d    = home;
          probe_d  = '0;
          case (action_i)
            hmlp_pkg::ACT_PUT, hmlp_pkg::ACT_FIND: begin
              state_d = hmlp_pkg::S_PROBE;
            end
            hmlp_pkg::ACT_CLEAR: begin
              count_d    = '0;
              clr_pend_d = 1'b1;
              clr_addr_d = '0;
              state_d    = hmlp_pkg::S_CLEAR;
            end
            default: begin
              resp_d  = hmlp_pkg::STS_NOT_FOUND;
              state_d = hmlp_pkg::S_RESP;
            end
          endcase
        end
      end

      hmlp_pkg::S_PROBE: begin
        if (!done) begin
          ram_raddr_o = next_idx;
          idx_d       = next_idx;
          probe_d     = probe_q + (AW+1)'(1);
        end else if (slot_free) begin
          // write back on insert or replace, count moves only on insert
          ram_we_o     = is_put_q && (hit || hole);
          out_valid_d  = 1'b1;
          out_status_d = probe_status;
          out_found_d  = (!is_put_q && hit) ? r_val : '0;
          if (is_put_q && hole) begin
            count_d     = count_q + CW'(1);
            out_count_d = count_q + CW'(1);
          end else begin
            out_count_d = count_q;
          end
          state_d = hmlp_pkg::S_IDLE;
        end
      end

      hmlp_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = resp_q;
          out_found_d  = '0;
          out_count_d  = count_q;
          state_d      = hmlp_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = hmlp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmlp_pkg::S_CLEAR;
      clr_addr_q  <= '0;
      clr_pend_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_pend_q  <= clr_pend_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_put_q     <= is_put_d;
    key_q        <= key_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    probe_q      <= probe_d;
    resp_q       <= resp_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_found_q;
  assign entry_count_o = out_count_q;

endmodule

// ===== hdl/hash_map_linear_probe_top.sv =====
// Key/value hash table with linear probing, no deletion.
// Input channel: in_valid_i / in_stall_o carry action_i, key_i, value_i.
// Output channel: out_valid_o / out_stall_i carry status_o, found_value_o
// and entry_count_o; one result beat for every input beat, in order.
// A put or find walks the buckets from the home bucket, one bucket per
// cycle out of a single-port-read memory with registered read data, and
// stops at a hit, an empty bucket or after every bucket in use. The result
// is written to an output register once the last probe is done and the
// register is free, and the next beat can be taken then.
// Clear writes every bucket empty, one a cycle; reset runs the same
// clearing pass with in_stall_o high; cfg writes are taken at any time.
// cfg_we_i / cfg_data_i set size_log2 (reset 10); write only while idle.
// When out_stall_i holds a result, the block still takes the next beat and
// works on it; it waits with the new result until the register frees.
// Depends on hmlp_pkg, hmlp_ram, hmlp_ctrl and the defines header.
`include "hash_map_linear_probe_top_defines.svh"

module hash_map_linear_probe_top #(
  parameter int DEPTH       = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [3:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [KEY_WIDTH-1:0]           key_i,
  input  logic [VALUE_WIDTH-1:0]         value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [VALUE_WIDTH-1:0]         found_value_o,
  output logic [$clog2(DEPTH+1)-1:0]     entry_count_o
);

  // buckets in use never exceed the largest power of two within DEPTH
  localparam int AW = $clog2(DEPTH + 1) - 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_WIDTH + VALUE_WIDTH + 1;

  logic [3:0]    size_log2_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= hmlp_pkg::SIZE_LOG2_RESET;
    end else if (cfg_we_i) begin
      size_log2_q <= cfg_data_i;
    end
  end

  hmlp_ctrl #(
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .size_log2_i   (size_log2_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  hmlp_ram #(
    .AW (AW),
    .EW (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an accepted beat keeps the block busy for at least the next cycle
  `HMLP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted beat did not make the block busy")
  // found_value is zero unless the lookup hit
  `HMLP_ASSERT(a_found_zero, out_valid_o && (status_o != hmlp_pkg::STS_FOUND) |-> found_value_o == '0, "nonzero found_value without a hit")
  // entry count never exceeds the number of buckets
  `HMLP_ASSERT(a_count_bound, out_valid_o |-> entry_count_o <= CW'(2 ** AW), "entry count above bucket count")

endmodule

// ===== tb/tb_hash_map_linear_probe_top.sv =====
// self-checking testbench for hash_map_linear_probe_top (linear-probe key/value table)
// a directed table then random put/find/clear/reserved traffic, checked against a table model here
// depends on hmlp_pkg and the block's rtl only
module tb_hash_map_linear_probe_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int RANDOM_ITEMS    = 1250;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    hmlp_pkg::status_e st;
    logic [31:0]       fv;
    logic [CNT_W-1:0]  cnt;
  } hm_result_t;

  typedef struct {
    bit          is_cfg;
    logic [3:0]  cfg_val;
    logic [1:0]  act;
    logic [31:0] key;
    logic [31:0] val;
    bit          typed;
    hm_result_t  want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [3:0]       cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       action_i;
  logic [31:0]      key_i;
  logic [31:0]      value_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       status_o;
  logic [31:0]      found_value_o;
  logic [CNT_W-1:0] entry_count_o;

  // table model
  bit               bucket_used [DEPTH];
  logic [31:0]      bucket_key  [DEPTH];
  logic [31:0]      bucket_val  [DEPTH];
  logic [CNT_W-1:0] entry_total;
  logic [3:0]       size_setting;

  hm_result_t pending_results[$];
  hm_result_t oldest;
  idle_mode_e idle_mode = IDLE_NONE;
  int         beat_no   = 0;
  int         errors    = 0;
  int         cycles    = 0;

  hash_map_linear_probe_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int buckets_in_use();
    int s;
    s = size_setting;
    if (s < hmlp_pkg::SIZE_LOG2_MIN) s = hmlp_pkg::SIZE_LOG2_MIN;
    if (s > ADDR_W) s = ADDR_W;
    return 1 << s;
  endfunction

  function automatic void table_step(input logic [1:0] act, input logic [31:0] key,
                                     input logic [31:0] val, output hm_result_t res);
    int cap;
    int mask;
    int home;
    int idx;
    res.st  = hmlp_pkg::STS_NOT_FOUND;
    res.fv  = '0;
    if (act == hmlp_pkg::ACT_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) bucket_used[i] = 1'b0;
      entry_total = '0;
      res.st = hmlp_pkg::STS_CLEARED;
    end else if (act == hmlp_pkg::ACT_PUT || act == hmlp_pkg::ACT_FIND) begin
      cap  = buckets_in_use();
      mask = cap - 1;
      home = int'((key ^ hmlp_pkg::HASH_SEED[31:0]) & 32'(mask));
      res.st = (act == hmlp_pkg::ACT_PUT) ? hmlp_pkg::STS_FULL : hmlp_pkg::STS_NOT_FOUND;
      for (int p = 0; p < cap; p++) begin
        idx = (home + p) & mask;
        if (!bucket_used[idx]) begin
          if (act == hmlp_pkg::ACT_PUT) begin
            bucket_used[idx] = 1'b1;
            bucket_key[idx]  = key;
            bucket_val[idx]  = val;
            entry_total++;
            res.st = hmlp_pkg::STS_INSERTED;
          end else begin
            res.st = hmlp_pkg::STS_NOT_FOUND;
          end
          break;
        end
        if (bucket_key[idx] == key) begin
          if (act == hmlp_pkg::ACT_PUT) begin
            bucket_val[idx] = val;
            res.st = hmlp_pkg::STS_REPLACED;
          end else begin
            res.fv = bucket_val[idx];
            res.st = hmlp_pkg::STS_FOUND;
          end
          break;
        end
      end
    end
    res.cnt = entry_total;
  endfunction

  function automatic bit sender_holds_off();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 63;
      IDLE_BOTH: return $urandom_range(0, 99) < 20;
      default:   return 1'b0;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_beat(input logic [1:0] act, input logic [31:0] key,
                           input logic [31:0] val, input bit typed,
                           input hm_result_t typed_res);
    hm_result_t res;
    while (sender_holds_off()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    table_step(act, key, val, res);
    pending_results.push_back(typed ? typed_res : res);
    beat_no++;
    idle_mode = idle_mode_e'((beat_no / 70) % 4);
    @(negedge clk_i);
  endtask

  // only once every result is back, so the block sits idle
  task automatic write_size(input logic [3:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_setting = v;
  endtask

  function automatic dir_row_t op_row(input logic [1:0] act, input logic [31:0] key,
                                      input logic [31:0] val);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.act     = act;
    row.key     = key;
    row.val     = val;
    row.typed   = 1'b0;
    row.want.st = hmlp_pkg::STS_NOT_FOUND;
    row.want.fv = '0;
    row.want.cnt = '0;
    return row;
  endfunction

  function automatic dir_row_t chk_row(input logic [1:0] act, input logic [31:0] key,
                                       input logic [31:0] val, input hmlp_pkg::status_e st,
                                       input logic [31:0] fv, input int cnt);
    dir_row_t row;
    row = op_row(act, key, val);
    row.typed    = 1'b1;
    row.want.st  = st;
    row.want.fv  = fv;
    row.want.cnt = CNT_W'(cnt);
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [3:0] v);
    dir_row_t row;
    row = op_row(hmlp_pkg::ACT_FIND, '0, '0);
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: out_stall_i <= $urandom_range(0, 99) < 63;
      IDLE_BOTH: out_stall_i <= $urandom_range(0, 99) < 20;
      default:   out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: status %0d value %h count %0d",
                 $time, status_o, found_value_o, entry_count_o);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (status_o !== oldest.st) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.st, status_o);
          errors++;
        end
        if (found_value_o !== oldest.fv) begin
          $display("%0t: found_value expected %h actual %h", $time, oldest.fv,
                   found_value_o);
          errors++;
        end
        if (entry_count_o !== oldest.cnt) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, oldest.cnt,
                   entry_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    dir_row_t    directed[$];
    logic [31:0] key_pool[$];
    hm_result_t  no_res;
    int          sizes[14];
    int          phase;
    int          sent;
    int          cap;
    int          pool_n;
    int          r;
    logic [1:0]  act;
    logic [31:0] k;
    logic [31:0] v;

    sizes      = '{0, 2, 3, 1, 5, 4, 10, 6, 2, 15, 3, 8, 4, 7};
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i   = '0;
    key_i      = '0;
    value_i    = '0;
    no_res     = '{hmlp_pkg::STS_NOT_FOUND, '0, '0};
    for (int i = 0; i < DEPTH; i++) bucket_used[i] = 1'b0;
    entry_total  = '0;
    size_setting = hmlp_pkg::SIZE_LOG2_RESET;

    // reset size first, then a 4-bucket table filled to the brim, then resizes
    directed.push_back(chk_row(hmlp_pkg::ACT_FIND, 32'h0, 32'h0, hmlp_pkg::STS_NOT_FOUND,
                               32'h0, 0));
    directed.push_back(chk_row(hmlp_pkg::ACT_PUT, 32'h0, 32'h0, hmlp_pkg::STS_INSERTED,
                               32'h0, 1));
    directed.push_back(chk_row(hmlp_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               hmlp_pkg::STS_INSERTED, 32'h0, 2));
    directed.push_back(chk_row(hmlp_pkg::ACT_FIND, 32'hFFFF_FFFF, 32'h0,
                               hmlp_pkg::STS_FOUND, 32'hFFFF_FFFF, 2));
    directed.push_back(chk_row(hmlp_pkg::ACT_PUT, 32'h0, 32'h1234_5678,
                               hmlp_pkg::STS_REPLACED, 32'h0, 2));
    directed.push_back(chk_row(hmlp_pkg::ACT_FIND, 32'h0, 32'hFFFF_FFFF,
                               hmlp_pkg::STS_FOUND, 32'h1234_5678, 2));
    directed.push_back(chk_row(ACT_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               hmlp_pkg::STS_NOT_FOUND, 32'h0, 2));
    directed.push_back(chk_row(hmlp_pkg::ACT_CLEAR, 32'h0, 32'h0, hmlp_pkg::STS_CLEARED,
                               32'h0, 0));
    directed.push_back(cfg_row(4'd0));
    for (int i = 1; i <= 4; i++)
      directed.push_back(chk_row(hmlp_pkg::ACT_PUT, i, 32'hA5A5_0000 | i,
                                 hmlp_pkg::STS_INSERTED, 32'h0, i));
    directed.push_back(chk_row(hmlp_pkg::ACT_PUT, 32'd5, 32'hDEAD_BEEF, hmlp_pkg::STS_FULL,
                               32'h0, 4));
    directed.push_back(chk_row(hmlp_pkg::ACT_FIND, 32'd6, 32'h0, hmlp_pkg::STS_NOT_FOUND,
                               32'h0, 4));
    directed.push_back(chk_row(hmlp_pkg::ACT_FIND, 32'd3, 32'h0, hmlp_pkg::STS_FOUND,
                               32'hA5A5_0003, 4));
    directed.push_back(chk_row(hmlp_pkg::ACT_PUT, 32'd2, 32'h0, hmlp_pkg::STS_REPLACED,
                               32'h0, 4));
    directed.push_back(cfg_row(4'd15));
    directed.push_back(op_row(hmlp_pkg::ACT_FIND, 32'd1, 32'h0));
    directed.push_back(op_row(hmlp_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    directed.push_back(op_row(hmlp_pkg::ACT_FIND, 32'h8000_0000, 32'h0));
    directed.push_back(cfg_row(4'd10));
    directed.push_back(chk_row(hmlp_pkg::ACT_CLEAR, 32'h0, 32'h0, hmlp_pkg::STS_CLEARED,
                               32'h0, 0));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_size(directed[i].cfg_val);
      else send_beat(directed[i].act, directed[i].key, directed[i].val,
                     directed[i].typed, directed[i].want);
    end

    // random phases, each at one table size; every fourth keeps the old contents
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_size(4'(sizes[phase % 14]));
      if (phase % 4 != 3) send_beat(hmlp_pkg::ACT_CLEAR, $urandom, $urandom, 1'b0, no_res);
      cap = buckets_in_use();
      pool_n = (cap <= 64) ? cap + cap / 2 + 1 : $urandom_range(40, 120);
      key_pool.delete();
      for (int i = 0; i < pool_n; i++) begin
        k = $urandom;
        // half the keys share a few home buckets so probe chains grow
        if ($urandom_range(0, 1)) k[9:0] = 10'($urandom_range(0, 7) * 97);
        key_pool.push_back(k);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        v = $urandom;
        if (r < 45) begin
          act = hmlp_pkg::ACT_PUT;
        end else if (r < 80) begin
          act = hmlp_pkg::ACT_FIND;
        end else if (r < 88) begin
          act = hmlp_pkg::ACT_FIND;
          k   = $urandom;
        end else if (r < 95) begin
          act = hmlp_pkg::ACT_PUT;
          k   = $urandom;
        end else if (r < 98) begin
          act = ACT_RESERVED;
          k   = $urandom;
        end else begin
          act = hmlp_pkg::ACT_CLEAR;
        end
        send_beat(act, k, v, 1'b0, no_res);
        sent++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // room for a stray beat after a full clearing pass
    repeat (1100) @(negedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hmlp_pkg.sv
hdl/hmlp_ram.sv
hdl/hmlp_ctrl.sv
hdl/hash_map_linear_probe_top.sv
tb/tb_hash_map_linear_probe_top.sv
